>>> sv/pgeg_pkg.sv
// Shared types and constants for the pairwise gravity energy/gradient pipeline.
// No dependencies; imported by every module of the block.
package pgeg_pkg;

    localparam int POS_W    = 32;
    localparam int MASS_W   = 32;
    localparam int G_W      = 32;
    localparam int DIFF_W   = 33;
    localparam int ROOT_W   = 33;
    localparam int SQ_W     = 2 * ROOT_W;
    localparam int GM_W     = G_W + MASS_W;
    localparam int PROD_W   = GM_W + MASS_W;
    localparam int NUM_W    = PROD_W + DIFF_W;
    localparam int L2_W     = 2 * ROOT_W;
    localparam int CUBE_W   = 3 * ROOT_W;
    localparam int FRAC_SH  = 16;
    localparam int Q_W      = 64;
    localparam int OUT_W    = 64;
    localparam int STATUS_W = 2;

    localparam logic [G_W-1:0]      G_RESET = G_W'(65536);
    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ZERO = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SAT  = 2'd2;

    typedef struct packed {
        logic        [MASS_W-1:0] mass_j;
        logic        [MASS_W-1:0] mass_i;
        logic signed [POS_W-1:0]  pos_j_y;
        logic signed [POS_W-1:0]  pos_j_x;
        logic signed [POS_W-1:0]  pos_i_y;
        logic signed [POS_W-1:0]  pos_i_x;
    } t_pair_in;

    typedef struct packed {
        logic [PROD_W-1:0] p;
        logic [DIFF_W-1:0] ax;
        logic [DIFF_W-1:0] ay;
        logic              sx;
        logic              sy;
        logic              zero;
    } t_pair_side;

    typedef struct packed {
        logic [SQ_W-1:0] s;
        t_pair_side      side;
    } t_front_out;

    typedef struct packed {
        logic [PROD_W-1:0] p;
        logic [ROOT_W-1:0] l;
        logic [NUM_W-1:0]  numx;
        logic [NUM_W-1:0]  numy;
        logic [CUBE_W-1:0] l3;
        logic              sx;
        logic              sy;
        logic              zero;
    } t_div_in;

endpackage

>>> sv/pgeg_front.sv
// Front end: separation, squared distance and mass product G*mi*mj, three stages.
// Depends on pgeg_pkg.
module pgeg_front import pgeg_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  t_pair_in         i_pair,
    input  logic [G_W-1:0]   i_grav,
    output logic             o_valid,
    output t_front_out       o_data
);

    logic [DIFF_W-1:0] w_dx, w_dy;
    logic [GM_W-1:0]   w_gm;

    logic              r1_v, r2_v, r3_v;
    logic [DIFF_W-1:0] r1_ax, r1_ay, r2_ax, r2_ay;
    logic              r1_sx, r1_sy, r1_zero, r2_sx, r2_sy, r2_zero;
    logic [GM_W-1:0]   r1_gm;
    logic [MASS_W-1:0] r1_mj;
    logic [SQ_W-1:0]   r2_sqx, r2_sqy;
    logic [GM_W-1:0]   r2_pp0, r2_pp1;
    t_front_out        r3_data;

    assign w_dx = {i_pair.pos_i_x[POS_W-1], i_pair.pos_i_x}
                - {i_pair.pos_j_x[POS_W-1], i_pair.pos_j_x};
    assign w_dy = {i_pair.pos_i_y[POS_W-1], i_pair.pos_i_y}
                - {i_pair.pos_j_y[POS_W-1], i_pair.pos_j_y};
    assign w_gm = i_grav * i_pair.mass_i;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_ax   <= w_dx[DIFF_W-1] ? -w_dx : w_dx;
            r1_ay   <= w_dy[DIFF_W-1] ? -w_dy : w_dy;
            r1_sx   <= w_dx[DIFF_W-1];
            r1_sy   <= w_dy[DIFF_W-1];
            r1_zero <= (w_dx == '0) && (w_dy == '0);
            r1_gm   <= w_gm;
            r1_mj   <= i_pair.mass_j;

            r2_sqx  <= SQ_W'(r1_ax * r1_ax);
            r2_sqy  <= SQ_W'(r1_ay * r1_ay);
            r2_pp0  <= GM_W'(r1_gm[31:0] * r1_mj);
            r2_pp1  <= GM_W'(r1_gm[GM_W-1:32] * r1_mj);
            r2_ax   <= r1_ax;
            r2_ay   <= r1_ay;
            r2_sx   <= r1_sx;
            r2_sy   <= r1_sy;
            r2_zero <= r1_zero;

            r3_data.s         <= r2_sqx + r2_sqy;
            r3_data.side.p    <= PROD_W'(r2_pp0) + (PROD_W'(r2_pp1) << 32);
            r3_data.side.ax   <= r2_ax;
            r3_data.side.ay   <= r2_ay;
            r3_data.side.sx   <= r2_sx;
            r3_data.side.sy   <= r2_sy;
            r3_data.side.zero <= r2_zero;
        end
    end

    assign o_valid = r3_v;
    assign o_data  = r3_data;

endmodule

>>> sv/pgeg_isqrt.sv
// Integer square root, one result bit per pipeline stage, with side data carried along.
// Depends on pgeg_pkg.
module pgeg_isqrt import pgeg_pkg::*; #(
    parameter int WR = ROOT_W,
    parameter int WS = 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [2*WR-1:0] i_sq,
    input  logic [WS-1:0]   i_side,
    output logic            o_valid,
    output logic [WR-1:0]   o_root,
    output logic [WS-1:0]   o_side
);

    logic              r_v    [0:WR-1];
    logic [2*WR-1:0]   r_rem  [0:WR-1];
    logic [WR-1:0]     r_root [0:WR-1];
    logic [WS-1:0]     r_side [0:WR-1];

    for (genvar k = 0; k < WR; k++) begin : g_stage
        localparam int B = WR - 1 - k;
        logic            w_v_in;
        logic [2*WR-1:0] w_rem_in;
        logic [WR-1:0]   w_root_in;
        logic [WS-1:0]   w_side_in;
        logic [2*WR-1:0] w_trial;

        if (k == 0) begin : g_first
            assign w_v_in    = i_valid;
            assign w_rem_in  = i_sq;
            assign w_root_in = '0;
            assign w_side_in = i_side;
        end else begin : g_next
            assign w_v_in    = r_v[k-1];
            assign w_rem_in  = r_rem[k-1];
            assign w_root_in = r_root[k-1];
            assign w_side_in = r_side[k-1];
        end

        assign w_trial = ({{WR{1'b0}}, w_root_in} << (B + 1))
                       | ({{(2*WR-1){1'b0}}, 1'b1} << (2 * B));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= w_v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[k] <= w_side_in;
                if (w_rem_in >= w_trial) begin
                    r_rem[k]  <= w_rem_in - w_trial;
                    r_root[k] <= w_root_in | ({{(WR-1){1'b0}}, 1'b1} << B);
                end else begin
                    r_rem[k]  <= w_rem_in;
                    r_root[k] <= w_root_in;
                end
            end
        end
    end

    assign o_valid = r_v[WR-1];
    assign o_root  = r_root[WR-1];
    assign o_side  = r_side[WR-1];

endmodule

>>> sv/pgeg_cube.sv
// Distance powers and gradient numerators: l^2, l^3, P*|dx|, P*|dy| in three stages.
// Depends on pgeg_pkg.
module pgeg_cube import pgeg_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [ROOT_W-1:0] i_root,
    input  t_pair_side        i_side,
    output logic              o_valid,
    output t_div_in           o_data
);

    localparam int PA_W = 32 + DIFF_W;
    localparam int LC_W = 32 + ROOT_W;
    localparam int LH_W = (L2_W - 64) + ROOT_W;

    logic              r1_v, r2_v, r3_v;
    logic [L2_W-1:0]   r1_l2;
    logic [PA_W-1:0]   r1_pax0, r1_pax1, r1_pax2, r1_pay0, r1_pay1, r1_pay2;
    logic [ROOT_W-1:0] r1_l, r2_l;
    logic [PROD_W-1:0] r1_p, r2_p;
    logic              r1_sx, r1_sy, r1_zero, r2_sx, r2_sy, r2_zero;
    logic [NUM_W-1:0]  r2_numx, r2_numy;
    logic [LC_W-1:0]   r2_lc0, r2_lc1;
    logic [LH_W-1:0]   r2_lc2;
    t_div_in           r3_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_l2   <= L2_W'(i_root * i_root);
            r1_pax0 <= PA_W'(i_side.p[31:0] * i_side.ax);
            r1_pax1 <= PA_W'(i_side.p[63:32] * i_side.ax);
            r1_pax2 <= PA_W'(i_side.p[95:64] * i_side.ax);
            r1_pay0 <= PA_W'(i_side.p[31:0] * i_side.ay);
            r1_pay1 <= PA_W'(i_side.p[63:32] * i_side.ay);
            r1_pay2 <= PA_W'(i_side.p[95:64] * i_side.ay);
            r1_l    <= i_root;
            r1_p    <= i_side.p;
            r1_sx   <= i_side.sx;
            r1_sy   <= i_side.sy;
            r1_zero <= i_side.zero;

            r2_numx <= NUM_W'(r1_pax0) + (NUM_W'(r1_pax1) << 32) + (NUM_W'(r1_pax2) << 64);
            r2_numy <= NUM_W'(r1_pay0) + (NUM_W'(r1_pay1) << 32) + (NUM_W'(r1_pay2) << 64);
            r2_lc0  <= LC_W'(r1_l2[31:0] * r1_l);
            r2_lc1  <= LC_W'(r1_l2[63:32] * r1_l);
            r2_lc2  <= LH_W'(r1_l2[L2_W-1:64] * r1_l);
            r2_l    <= r1_l;
            r2_p    <= r1_p;
            r2_sx   <= r1_sx;
            r2_sy   <= r1_sy;
            r2_zero <= r1_zero;

            r3_data.l3   <= CUBE_W'(r2_lc0) + (CUBE_W'(r2_lc1) << 32)
                          + (CUBE_W'(r2_lc2) << 64);
            r3_data.numx <= r2_numx;
            r3_data.numy <= r2_numy;
            r3_data.l    <= r2_l;
            r3_data.p    <= r2_p;
            r3_data.sx   <= r2_sx;
            r3_data.sy   <= r2_sy;
            r3_data.zero <= r2_zero;
        end
    end

    assign o_valid = r3_v;
    assign o_data  = r3_data;

endmodule

>>> sv/pgeg_div.sv
// Restoring divider, one quotient bit per stage after an overflow check stage.
// Depends on pgeg_pkg; quotient is Q_W bits, overflow flags a quotient of 2^Q_W or more.
module pgeg_div import pgeg_pkg::*; #(
    parameter int WN = PROD_W,
    parameter int WD = ROOT_W,
    parameter int WS = 1
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  logic [WN-1:0]  i_num,
    input  logic [WD-1:0]  i_den,
    input  logic [WS-1:0]  i_side,
    output logic           o_valid,
    output logic [Q_W-1:0] o_quot,
    output logic           o_ovf,
    output logic [WS-1:0]  o_side
);

    localparam int WC = WD + Q_W;
    localparam int WH = WN - Q_W;

    logic [WC-1:0]  w_num_ext, w_den_ext;

    logic           r0_v, r0_ovf;
    logic [WD-1:0]  r0_rem, r0_den;
    logic [Q_W-1:0] r0_sh;
    logic [WS-1:0]  r0_side;

    logic           r_v    [0:Q_W-1];
    logic           r_ovf  [0:Q_W-1];
    logic [WD-1:0]  r_rem  [0:Q_W-1];
    logic [WD-1:0]  r_den  [0:Q_W-1];
    logic [Q_W-1:0] r_sh   [0:Q_W-1];
    logic [WS-1:0]  r_side [0:Q_W-1];

    assign w_num_ext = {{(WC-WN){1'b0}}, i_num};
    assign w_den_ext = {i_den, {Q_W{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
        end else if (i_en) begin
            r0_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_ovf  <= w_num_ext >= w_den_ext;
            r0_rem  <= {{(WD-WH){1'b0}}, i_num[WN-1:Q_W]};
            r0_sh   <= i_num[Q_W-1:0];
            r0_den  <= i_den;
            r0_side <= i_side;
        end
    end

    for (genvar k = 0; k < Q_W; k++) begin : g_stage
        logic           w_v_in, w_ovf_in, w_ge;
        logic [WD-1:0]  w_rem_in, w_den_in;
        logic [Q_W-1:0] w_sh_in;
        logic [WS-1:0]  w_side_in;
        logic [WD:0]    w_try, w_diff;

        if (k == 0) begin : g_first
            assign w_v_in    = r0_v;
            assign w_ovf_in  = r0_ovf;
            assign w_rem_in  = r0_rem;
            assign w_den_in  = r0_den;
            assign w_sh_in   = r0_sh;
            assign w_side_in = r0_side;
        end else begin : g_next
            assign w_v_in    = r_v[k-1];
            assign w_ovf_in  = r_ovf[k-1];
            assign w_rem_in  = r_rem[k-1];
            assign w_den_in  = r_den[k-1];
            assign w_sh_in   = r_sh[k-1];
            assign w_side_in = r_side[k-1];
        end

        assign w_try  = {w_rem_in, w_sh_in[Q_W-1]};
        assign w_ge   = w_try >= {1'b0, w_den_in};
        assign w_diff = w_try - {1'b0, w_den_in};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= w_v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ovf[k]  <= w_ovf_in;
                r_den[k]  <= w_den_in;
                r_side[k] <= w_side_in;
                r_sh[k]   <= {w_sh_in[Q_W-2:0], w_ge};
                r_rem[k]  <= w_ge ? w_diff[WD-1:0] : w_try[WD-1:0];
            end
        end
    end

    assign o_valid = r_v[Q_W-1];
    assign o_quot  = r_sh[Q_W-1];
    assign o_ovf   = r_ovf[Q_W-1];
    assign o_side  = r_side[Q_W-1];

endmodule

>>> sv/pairwise_gravity_energy_gradient.sv
// Pairwise Newtonian gravity, 2D fixed point: energy -G*mi*mj/l and gradient G*mi*mj*d/l^3.
// Pipeline stages: front 3, root 33, powers 3, divide 65, output 1. Throughput: one word
// per cycle while the output is not stalled, set by the fully pipelined dividers.
// Reset (i_rst_n low, synchronous) empties the pipeline and sets G to 1.0.
// Depends on pgeg_pkg, pgeg_front, pgeg_isqrt, pgeg_cube, pgeg_div.
module pairwise_gravity_energy_gradient import pgeg_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [G_W-1:0]        i_cfg_wr_data,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // pos_i_x, pos_i_y, pos_j_x, pos_j_y, mass_i, mass_j
    input  logic [6*POS_W-1:0]    i_s_tdata,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // energy_term, grad_x, grad_y
    output logic [3*OUT_W-1:0]    o_m_tdata,
    // status
    output logic [STATUS_W-1:0]   o_m_tuser
);

    localparam logic [OUT_W-1:0] NEG_LIM = {1'b1, {(OUT_W-1){1'b0}}};
    localparam logic [OUT_W-1:0] POS_LIM = {1'b0, {(OUT_W-1){1'b1}}};

    function automatic logic [OUT_W:0] sat_pack(input logic [OUT_W-1:0] q,
                                                input logic ovf, input logic neg);
        logic [OUT_W-1:0] mag;
        logic             sat;
        mag = ovf ? '1 : q;
        sat = 1'b0;
        if (neg) begin
            if (mag > NEG_LIM) begin
                mag = NEG_LIM;
                sat = 1'b1;
            end
            mag = ~mag + 1'b1;
        end else if (mag > POS_LIM) begin
            mag = POS_LIM;
            sat = 1'b1;
        end
        return {sat, mag};
    endfunction

    logic [G_W-1:0]      r_grav;
    logic                r_out_v;
    logic [3*OUT_W-1:0]  r_out_data;
    logic [STATUS_W-1:0] r_out_user;

    logic                w_en, w_in_v;
    t_pair_in            w_pair;
    logic                w_front_v, w_root_v, w_cube_v;
    t_front_out          w_front;
    logic [ROOT_W-1:0]   w_root;
    t_pair_side          w_root_side;
    t_div_in             w_cube;
    logic                w_ve, w_vx, w_vy, w_last_v;
    logic [Q_W-1:0]      w_qe, w_qx, w_qy;
    logic                w_oe, w_ox, w_oy;
    logic                w_zero, w_sx, w_sy;
    logic [OUT_W:0]      w_pe, w_px, w_py;
    logic [3*OUT_W-1:0]  n_out_data;
    logic [STATUS_W-1:0] n_out_user;

    assign w_en     = !w_last_v || !r_out_v || i_m_tready;
    assign w_in_v   = i_s_tvalid && w_en;
    assign w_pair   = t_pair_in'(i_s_tdata);
    assign w_last_v = w_ve && w_vx && w_vy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grav <= G_RESET;
        end else if (i_cfg_wr_en) begin
            r_grav <= i_cfg_wr_data;
        end
    end

    pgeg_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_in_v),
        .i_pair  (w_pair),
        .i_grav  (r_grav),
        .o_valid (w_front_v),
        .o_data  (w_front)
    );

    pgeg_isqrt #(.WR(ROOT_W), .WS($bits(t_pair_side))) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_front_v),
        .i_sq    (w_front.s),
        .i_side  (w_front.side),
        .o_valid (w_root_v),
        .o_root  (w_root),
        .o_side  (w_root_side)
    );

    pgeg_cube u_cube (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_root_v),
        .i_root  (w_root),
        .i_side  (w_root_side),
        .o_valid (w_cube_v),
        .o_data  (w_cube)
    );

    pgeg_div #(.WN(PROD_W), .WD(ROOT_W), .WS(1)) u_div_e (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_cube_v),
        .i_num   (w_cube.p),
        .i_den   (w_cube.l),
        .i_side  (w_cube.zero),
        .o_valid (w_ve),
        .o_quot  (w_qe),
        .o_ovf   (w_oe),
        .o_side  (w_zero)
    );

    pgeg_div #(.WN(NUM_W + FRAC_SH), .WD(CUBE_W), .WS(1)) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_cube_v),
        .i_num   ({w_cube.numx, {FRAC_SH{1'b0}}}),
        .i_den   (w_cube.l3),
        .i_side  (w_cube.sx),
        .o_valid (w_vx),
        .o_quot  (w_qx),
        .o_ovf   (w_ox),
        .o_side  (w_sx)
    );

    pgeg_div #(.WN(NUM_W + FRAC_SH), .WD(CUBE_W), .WS(1)) u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_cube_v),
        .i_num   ({w_cube.numy, {FRAC_SH{1'b0}}}),
        .i_den   (w_cube.l3),
        .i_side  (w_cube.sy),
        .o_valid (w_vy),
        .o_quot  (w_qy),
        .o_ovf   (w_oy),
        .o_side  (w_sy)
    );

    always_comb begin
        w_pe = sat_pack(w_qe, w_oe, 1'b1);
        w_px = sat_pack(w_qx, w_ox, w_sx);
        w_py = sat_pack(w_qy, w_oy, w_sy);
        if (w_zero) begin
            n_out_data = '0;
            n_out_user = ST_ZERO;
        end else begin
            n_out_data = {w_py[OUT_W-1:0], w_px[OUT_W-1:0], w_pe[OUT_W-1:0]};
            n_out_user = (w_pe[OUT_W] || w_px[OUT_W] || w_py[OUT_W]) ? ST_SAT : ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_last_v && w_en) begin
            r_out_v <= 1'b1;
        end else if (i_m_tready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_last_v && w_en) begin
            r_out_data <= n_out_data;
            r_out_user <= n_out_user;
        end
    end

    assign o_s_tready = w_en;
    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;

`ifndef ASSERT_OFF
    a_zero_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser == ST_ZERO) |-> (o_m_tdata == '0))
        else $error("zero-distance word carries nonzero data");

    a_energy_neg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[OUT_W-1:0] != '0) |-> o_m_tdata[OUT_W-1])
        else $error("nonzero energy term is not negative");

    a_stall_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready && w_last_v) |-> !o_s_tready)
        else $error("input accepted while pipeline is blocked");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid right after reset");
`endif

endmodule

>>> dv/pairwise_gravity_energy_gradient_tb.sv
// Self-checking testbench for pairwise_gravity_energy_gradient: streams particle pairs,
// predicts energy, gradient and status with exact wide integer arithmetic.
// Depends on pgeg_pkg and the RTL of the block.
module pairwise_gravity_energy_gradient_tb;
    import pgeg_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY   = 104;
    localparam int WDOG_MAX  = 20000;
    localparam int N_RANDOM  = 930;

    typedef struct packed {
        logic signed [63:0] energy;
        logic signed [63:0] gx;
        logic signed [63:0] gy;
        logic [STATUS_W-1:0] status;
    } t_force;

    typedef struct {
        logic [31:0] pix, piy, pjx, pjy, mi, mj;
        logic        chk;
        t_force      res;
    } t_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_wr_en;
    logic [G_W-1:0]       i_cfg_wr_data;
    logic                 i_s_tvalid;
    logic                 o_s_tready;
    logic [6*POS_W-1:0]   i_s_tdata;
    logic                 o_m_tvalid;
    logic                 i_m_tready;
    logic [3*OUT_W-1:0]   o_m_tdata;
    logic [STATUS_W-1:0]  o_m_tuser;

    pairwise_gravity_energy_gradient u_top (.*);

    logic [31:0] grav_g;
    t_force      force_q[$];
    int          n_fail;
    int          idle_cnt = 0;
    bit          rx_hold;
    bit          calm;
    bit          done;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [63:0] clamp_mag(logic [191:0] mag, bit neg, ref bit sat);
        logic [191:0] lim;
        lim = neg ? (192'd1 << 63) : ((192'd1 << 63) - 1);
        if (mag > lim) begin
            mag = lim;
            sat = 1'b1;
        end
        return neg ? (~mag[63:0] + 64'd1) : mag[63:0];
    endfunction

    function automatic t_force pair_force(logic [31:0] pix, piy, pjx, pjy, mi, mj);
        t_force r;
        logic signed [33:0] dx, dy;
        logic [191:0] ax, ay, s, l, p, l3, t;
        bit sat;
        sat = 1'b0;
        dx = $signed(pix) - $signed(pjx);
        dy = $signed(piy) - $signed(pjy);
        ax = dx < 0 ? -dx : dx;
        ay = dy < 0 ? -dy : dy;
        if (ax == 0 && ay == 0) begin
            r = '{64'd0, 64'd0, 64'd0, ST_ZERO};
            return r;
        end
        s = ax * ax + ay * ay;
        l = 0;
        for (int b = 33; b >= 0; b--) begin
            t = l | (192'd1 << b);
            if (t * t <= s) l = t;
        end
        p = 192'(grav_g) * 192'(mi) * 192'(mj);
        l3 = l * l * l;
        r.energy = clamp_mag(p / l, 1'b1, sat);
        r.gx = clamp_mag(((p * ax) << 16) / l3, dx < 0, sat);
        r.gy = clamp_mag(((p * ay) << 16) / l3, dy < 0, sat);
        r.status = sat ? ST_SAT : ST_OK;
        return r;
    endfunction

    task automatic send_pair(logic [31:0] pix, piy, pjx, pjy, mi, mj, bit chk, t_force want);
        t_force f;
        if (!calm && $urandom_range(0, 5) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        i_s_tdata  <= {mj, mi, pjy, pjx, piy, pix};
        i_s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        f = pair_force(pix, piy, pjx, pjy, mi, mj);
        if (chk && f !== want) begin
            $error("table entry exp %h predicted %h", want, f);
            n_fail++;
        end
        force_q.push_back(chk ? want : f);
    endtask

    task automatic drain_and_wait();
        i_s_tvalid <= 1'b0;
        while (force_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic write_g(logic [31:0] g);
        drain_and_wait();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= g;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        grav_g = g;
    endtask

    function automatic logic [31:0] rnd_pos(int mode);
        case (mode)
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
            default: return 32'($signed($urandom_range(0, 600)) - 300) << 16;
        endcase
    endfunction

    function automatic logic [31:0] rnd_mass();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'd0;
            default: return $urandom_range(1, 32'h0040_0000);
        endcase
    endfunction

    // receiver: random stalls, one long hold-off, none in the last part
    always @(posedge i_clk) begin
        if (!i_rst_n || calm)
            i_m_tready <= 1'b1;
        else if (rx_hold)
            i_m_tready <= 1'b0;
        else
            i_m_tready <= ($urandom_range(0, 4) != 0);
    end

    // checker
    always @(posedge i_clk) begin
        t_force want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (force_q.size() == 0) begin
                $error("word with nothing expected");
                n_fail++;
            end else begin
                want = force_q.pop_front();
                if (o_m_tdata[63:0] !== want.energy) begin
                    $error("energy_term exp %h got %h", want.energy, o_m_tdata[63:0]);
                    n_fail++;
                end
                if (o_m_tdata[127:64] !== want.gx) begin
                    $error("grad_x exp %h got %h", want.gx, o_m_tdata[127:64]);
                    n_fail++;
                end
                if (o_m_tdata[191:128] !== want.gy) begin
                    $error("grad_y exp %h got %h", want.gy, o_m_tdata[191:128]);
                    n_fail++;
                end
                if (o_m_tuser !== want.status) begin
                    $error("status exp %0d got %0d", want.status, o_m_tuser);
                    n_fail++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || done)
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= WDOG_MAX) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        t_row rows[$];
        t_force z;
        int mode;
        z = '0;
        n_fail = 0;
        rx_hold = 1'b0;
        calm = 1'b0;
        done = 1'b0;
        grav_g = G_RESET;
        i_rst_n = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_wr_data = '0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // same point, zero masses, extremes, saturation, each sign
        rows.push_back('{32'h0, 32'h0, 32'h0, 32'h0, 32'h10000, 32'h10000, 1, '{0, 0, 0, ST_ZERO}});
        rows.push_back('{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                         32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, '{0, 0, 0, ST_ZERO}});
        rows.push_back('{32'h10000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h10000, 1, z});
        rows.push_back('{32'h10000, 32'h0, 32'h0, 32'h0, 32'h10000, 32'h0, 1, z});
        rows.push_back('{32'h10000, 32'h0, 32'h0, 32'h0, 32'h10000, 32'h10000, 1,
                         '{-64'sh1_0000_0000, 64'sh1_0000_0000, 0, ST_OK}});
        rows.push_back('{32'h0, 32'h10000, 32'h0, 32'h0, 32'h10000, 32'h10000, 0, z});
        rows.push_back('{32'h0, 32'h0, 32'h10000, 32'h10000, 32'h20000, 32'h30000, 0, z});
        rows.push_back('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                         32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, z});
        rows.push_back('{32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                         32'h1, 32'h1, 0, z});
        rows.push_back('{32'h1, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, z});
        rows.push_back('{32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'h1, 0, z});
        rows.push_back('{32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555,
                         32'h5555_5555, 32'hAAAA_AAAA, 0, z});
        rows.push_back('{32'hFFFF_0000, 32'h3, 32'h1_0000, 32'hFFFF_FFFD, 32'h8000, 32'h7_0000, 0, z});
        foreach (rows[k])
            send_pair(rows[k].pix, rows[k].piy, rows[k].pjx, rows[k].pjy,
                      rows[k].mi, rows[k].mj, rows[k].chk, rows[k].res);

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == 150) write_g(32'd0);
            if (n == 250) write_g(32'hFFFF_FFFF);
            if (n == 350) write_g($urandom());
            if (n == 450) begin
                write_g(32'd1);
                fork
                    begin
                        rx_hold = 1'b1;
                        repeat (400) @(posedge i_clk);
                        rx_hold = 1'b0;
                    end
                join_none
            end
            if (n == 600) begin
                drain_and_wait();
                write_g(32'h0003_2000);
            end
            if (n == 800) calm = 1'b1;
            mode = $urandom_range(0, 2);
            if ($urandom_range(0, 30) == 0) begin
                logic [31:0] px, py;
                px = rnd_pos(mode);
                py = rnd_pos(mode);
                send_pair(px, py, px, py, rnd_mass(), rnd_mass(), 0, z);
            end else
                send_pair(rnd_pos(mode), rnd_pos(mode), rnd_pos(mode), rnd_pos(mode),
                          rnd_mass(), rnd_mass(), 0, z);
        end
        i_s_tvalid <= 1'b0;

        fork
            begin
                while (force_q.size() != 0) @(posedge i_clk);
                repeat (LATENCY + 4) @(posedge i_clk);
            end
            begin
                repeat (WDOG_MAX) @(posedge i_clk);
                n_fail++;
            end
        join_any
        done = 1'b1;
        if (n_fail == 0 && force_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
